[rtl/core/hcbd_pkg.sv]
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared constants and types for the chunked body decoder: the line length
// limit, the result kind codes and the classification of one size line byte.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  // Longest size or trailer line, CR LF included, is LineCap - 1 bytes.
  localparam int unsigned LineCap = 64;
  localparam int unsigned LenW    = $clog2(LineCap);

  // Input action codes.
  localparam logic [1:0] ActByte  = 2'd0;
  localparam logic [1:0] ActBegin = 2'd1;
  localparam logic [1:0] ActEnd   = 2'd2;

  // Result kind codes.
  localparam logic [2:0] KindPayload  = 3'd0;
  localparam logic [2:0] KindComplete = 3'd1;
  localparam logic [2:0] KindTooLong  = 3'd2;
  localparam logic [2:0] KindBadSize  = 3'd3;
  localparam logic [2:0] KindBadEnd   = 3'd4;
  localparam logic [2:0] KindTrunc    = 3'd5;

  // Character codes.
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChNul   = 8'h00;

  // Classification of one byte of a chunk size line.
  typedef struct packed {
    logic       stop;    // terminates the hex scan
    logic       digit;   // is a hex digit
    logic [3:0] value;   // digit value when digit is set
  } hcbd_scan_t;

endpackage

[rtl/core/hcbd_scan.sv]
// ----------------------------------------------------------------------------
// hcbd_scan
// Classifies one byte of a chunk size line as a scan stop character, a hex
// digit with its value, or neither.
// ----------------------------------------------------------------------------
module hcbd_scan (
  input  logic [7:0]          byte_i,
  output hcbd_pkg::hcbd_scan_t scan_o
);
  import hcbd_pkg::*;

  // Stop characters and hex digit decoding.
  always_comb begin
    scan_o.stop  = (byte_i == ChSemi) || (byte_i == ChCr) || (byte_i == ChLf) ||
                   (byte_i == ChSpace) || (byte_i == ChNul);
    scan_o.digit = 1'b0;
    scan_o.value = 4'd0;
    if (byte_i >= 8'h30 && byte_i <= 8'h39) begin
      scan_o.digit = 1'b1;
      scan_o.value = byte_i[3:0];
    end else if ((byte_i >= 8'h61 && byte_i <= 8'h66) ||
                 (byte_i >= 8'h41 && byte_i <= 8'h46)) begin
      // Letters a to f and A to F share the low three bits: 1 to 6.
      scan_o.digit = 1'b1;
      scan_o.value = 4'd9 + {1'b0, byte_i[2:0]};
    end
  end

endmodule

[rtl/core/hcbd_core.sv]
// ----------------------------------------------------------------------------
// hcbd_core
// Decoder state and the combinational step: takes one registered item, updates
// the phase, line and chunk counters, and produces at most one result.
// ----------------------------------------------------------------------------
module hcbd_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [1:0] action_i,
  input  logic [7:0] data_byte_i,
  output logic       res_valid_o,
  output logic [2:0] res_kind_o,
  output logic [7:0] res_byte_o
);
  import hcbd_pkg::*;

  // Phase codes.
  localparam logic [2:0] PhSize    = 3'd0;
  localparam logic [2:0] PhData    = 3'd1;
  localparam logic [2:0] PhCr      = 3'd2;
  localparam logic [2:0] PhLf      = 3'd3;
  localparam logic [2:0] PhTrailer = 3'd4;
  localparam logic [2:0] PhDone    = 3'd5;

  logic [2:0]      phase_q, phase_d;
  logic [LenW-1:0] len_q, len_d;
  logic            prev_cr_q, prev_cr_d;
  logic [31:0]     size_q, size_d;
  logic            digit_seen_q, digit_seen_d;
  logic            stopped_q, stopped_d;
  logic            failed_q, failed_d;
  logic [31:0]     remain_q, remain_d;
  logic            first_zero_q, first_zero_d;

  hcbd_scan_t scan;

  hcbd_scan u_scan (
    .byte_i (data_byte_i),
    .scan_o (scan)
  );

  // Next state and result for one item.
  always_comb begin
    logic        crlf_hit;
    logic [31:0] remain_dec;
    phase_d      = phase_q;
    len_d        = len_q;
    prev_cr_d    = prev_cr_q;
    size_d       = size_q;
    digit_seen_d = digit_seen_q;
    stopped_d    = stopped_q;
    failed_d     = failed_q;
    remain_d     = remain_q;
    first_zero_d = first_zero_q;
    res_valid_o  = 1'b0;
    res_kind_o   = KindPayload;
    res_byte_o   = 8'd0;
    crlf_hit     = 1'b0;
    remain_dec   = remain_q;

    if (action_i == ActBegin) begin
      phase_d      = PhSize;
      remain_d     = 32'd0;
      len_d        = '0;
      prev_cr_d    = 1'b0;
      size_d       = 32'd0;
      digit_seen_d = 1'b0;
      stopped_d    = 1'b0;
      failed_d     = 1'b0;
      first_zero_d = 1'b0;
    end else if (action_i == ActEnd) begin
      if (phase_q != PhDone) begin
        res_valid_o = 1'b1;
        res_kind_o  = KindTrunc;
        phase_d     = PhDone;
      end
    end else if (action_i == ActByte && phase_q != PhDone) begin
      unique case (phase_q)
        PhSize, PhTrailer: begin
          if (len_q >= LenW'(LineCap - 1)) begin
            res_valid_o = 1'b1;
            res_kind_o  = KindTooLong;
            phase_d     = PhDone;
          end else begin
            len_d = len_q + 1'b1;
            if (len_q == '0) begin
              first_zero_d = (data_byte_i == ChNul);
            end
            // Hex scan of the size field.
            if (phase_q == PhSize && !stopped_q && !failed_q) begin
              if (scan.stop) begin
                stopped_d = 1'b1;
              end else if (!scan.digit) begin
                failed_d = 1'b1;
              end else begin
                digit_seen_d = 1'b1;
                if (size_q[31:28] != 4'd0) begin
                  failed_d = 1'b1;
                end else begin
                  size_d = {size_q[27:0], scan.value};
                end
              end
            end
            crlf_hit  = prev_cr_q && (data_byte_i == ChLf) && (len_q != '0);
            prev_cr_d = (data_byte_i == ChCr);
            if (crlf_hit) begin
              if (phase_q == PhSize) begin
                if (failed_d || !digit_seen_d) begin
                  res_valid_o = 1'b1;
                  res_kind_o  = KindBadSize;
                  phase_d     = PhDone;
                end else begin
                  if (size_d == 32'd0) begin
                    phase_d = PhTrailer;
                  end else begin
                    remain_d = size_d;
                    phase_d  = PhData;
                  end
                  len_d        = '0;
                  prev_cr_d    = 1'b0;
                  size_d       = 32'd0;
                  digit_seen_d = 1'b0;
                  stopped_d    = 1'b0;
                  failed_d     = 1'b0;
                  first_zero_d = 1'b0;
                end
              end else if (len_d == LenW'(2) || first_zero_d) begin
                // An empty trailer line, or one that opens with NUL, closes the body.
                res_valid_o = 1'b1;
                res_kind_o  = KindComplete;
                phase_d     = PhDone;
              end else begin
                len_d        = '0;
                prev_cr_d    = 1'b0;
                size_d       = 32'd0;
                digit_seen_d = 1'b0;
                stopped_d    = 1'b0;
                failed_d     = 1'b0;
                first_zero_d = 1'b0;
              end
            end
          end
        end
        PhData: begin
          if (remain_q != 32'd0) begin
            remain_dec = remain_q - 32'd1;
          end
          remain_d = remain_dec;
          if (remain_dec == 32'd0) begin
            phase_d = PhCr;
          end
          res_valid_o = 1'b1;
          res_kind_o  = KindPayload;
          res_byte_o  = data_byte_i;
        end
        PhCr: begin
          if (data_byte_i != ChCr) begin
            res_valid_o = 1'b1;
            res_kind_o  = KindBadEnd;
            phase_d     = PhDone;
          end else begin
            phase_d = PhLf;
          end
        end
        PhLf: begin
          if (data_byte_i != ChLf) begin
            res_valid_o = 1'b1;
            res_kind_o  = KindBadEnd;
            phase_d     = PhDone;
          end else begin
            phase_d      = PhSize;
            len_d        = '0;
            prev_cr_d    = 1'b0;
            size_d       = 32'd0;
            digit_seen_d = 1'b0;
            stopped_d    = 1'b0;
            failed_d     = 1'b0;
            first_zero_d = 1'b0;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  // State registers, updated only when an item is stepped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhSize;
      len_q        <= '0;
      prev_cr_q    <= 1'b0;
      size_q       <= 32'd0;
      digit_seen_q <= 1'b0;
      stopped_q    <= 1'b0;
      failed_q     <= 1'b0;
      remain_q     <= 32'd0;
      first_zero_q <= 1'b0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      len_q        <= len_d;
      prev_cr_q    <= prev_cr_d;
      size_q       <= size_d;
      digit_seen_q <= digit_seen_d;
      stopped_q    <= stopped_d;
      failed_q     <= failed_d;
      remain_q     <= remain_d;
      first_zero_q <= first_zero_d;
    end
  end

endmodule

[rtl/core/http_chunked_body_decoder.sv]
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Strips HTTP/1.1 chunked transfer framing from a byte stream and passes on
// the chunk payload, followed by a completion or error result.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): each transfer carries an action
//   (body byte, begin new body, end of input) and a data byte.
//   Output channel (out_valid_o / out_stall_i): each transfer carries a result
//   kind (payload byte, complete, line too long, bad size, bad chunk end,
//   truncated) and the payload byte, zero for non-payload kinds.
//   Path: an accepted item is held in the input register, stepped through the
//   decoder when the output register is free or draining, and its result is
//   registered in the output register, from which it is transferred.
//   Throughput: one item per cycle unless the output stalls; decoder state
//   updates once per item, also for items with no result (framing bytes, begin).
//   Stall: while the output register holds a result that is stalled, the
//   input register is held and in_stall_o rises once it is occupied.
//   After any terminal result, body bytes and end of input are dropped until
//   a begin item arrives.
//   Reset: empties both registers and puts the decoder at the start of a size
//   line, as a begin item does.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] action_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] kind_o,
  output logic [7:0] out_byte_o
);
  import hcbd_pkg::*;

  logic       in_vld_q;
  logic [1:0] action_q;
  logic [7:0] byte_q;
  logic       out_vld_q;
  logic [2:0] kind_q;
  logic [7:0] obyte_q;

  logic       step;
  logic       res_valid;
  logic [2:0] res_kind;
  logic [7:0] res_byte;

  // The held item steps when the output register is free or draining.
  assign step       = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !step;

  hcbd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .action_i    (action_q),
    .data_byte_i (byte_q),
    .res_valid_o (res_valid),
    .res_kind_o  (res_kind),
    .res_byte_o  (res_byte)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      action_q <= action_i;
      byte_q   <= data_byte_i;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= res_valid;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      kind_q  <= res_kind;
      obyte_q <= res_byte;
    end
  end

  assign out_valid_o = out_vld_q;
  assign kind_o      = kind_q;
  assign out_byte_o  = obyte_q;

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked body decoder testbench
// Streams directed and random HTTP chunked bodies into the decoder, predicts
// every payload byte and terminal result in a local decoder model, and checks
// each output transfer against the oldest outstanding prediction. Both
// channels idle and stall at random, and one long output hold-off forces the
// decoder to stall its input.
// ----------------------------------------------------------------------------
module testbench;
  import hcbd_pkg::*;

  localparam logic [1:0]  ActUnused     = 2'd3;
  localparam int unsigned ItemTarget    = 1450;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned SettleCycles  = 10;

  typedef enum logic [2:0] {
    PhSize, PhData, PhCr, PhLf, PhTrailer, PhDone
  } dec_phase_e;

  typedef struct {
    logic [1:0] act;
    logic [7:0] data;
  } item_t;

  typedef struct {
    logic [2:0] kind;
    logic [7:0] data;
  } result_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [1:0] action_i;
  logic [7:0] data_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [2:0] kind_o;
  logic [7:0] out_byte_o;

  // Predicted results not yet seen on the output, oldest first.
  result_t     awaited_results[$];
  // Items waiting to be sent.
  item_t       body_items[$];
  int unsigned error_count  = 0;
  int unsigned live_items   = 0;
  int unsigned burst_left   = 0;
  int unsigned quiet_cycles = 0;
  bit          hold_off_req = 1'b0;

  // Local copy of the decoder state.
  dec_phase_e  dec_phase;
  int unsigned line_len;
  bit          prev_cr;
  bit          digit_seen;
  bit          scan_stop;
  bit          scan_bad;
  bit          first_nul;
  logic [31:0] size_acc;
  logic [31:0] chunk_left;

  http_chunked_body_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .data_byte_i(data_byte_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .kind_o     (kind_o),
    .out_byte_o (out_byte_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------------

  function automatic void clear_line_state();
    line_len   = 0;
    prev_cr    = 1'b0;
    size_acc   = '0;
    digit_seen = 1'b0;
    scan_stop  = 1'b0;
    scan_bad   = 1'b0;
    first_nul  = 1'b0;
  endfunction

  function automatic void restart_decoder();
    dec_phase  = PhSize;
    chunk_left = '0;
    clear_line_state();
  endfunction

  // Any result other than a payload byte ends the body.
  function automatic void expect_result(logic [2:0] kind, logic [7:0] data);
    result_t r;
    r.kind = kind;
    r.data = data;
    awaited_results.push_back(r);
    if (kind != KindPayload) begin
      dec_phase = PhDone;
    end
  endfunction

  // Hex scan of one size line byte; it stops at the first delimiter.
  function automatic void scan_size_char(logic [7:0] b);
    logic [3:0] nib;
    if (scan_stop || scan_bad) begin
      return;
    end
    if (b == ChSemi || b == ChCr || b == ChLf || b == ChSpace || b == ChNul) begin
      scan_stop = 1'b1;
      return;
    end
    if (b >= 8'h30 && b <= 8'h39) begin
      nib = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      nib = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      nib = 4'(b - 8'h37);
    end else begin
      scan_bad = 1'b1;
      return;
    end
    digit_seen = 1'b1;
    if (size_acc > (32'hFFFF_FFFF - {28'd0, nib}) / 32'd16) begin
      scan_bad = 1'b1;
    end else begin
      size_acc = {size_acc[27:0], nib};
    end
  endfunction

  // One byte of a size line or a trailer line.
  function automatic void line_char(logic [7:0] b);
    bit ends;
    if (line_len + 1 >= LineCap) begin
      expect_result(KindTooLong, 8'h00);
      return;
    end
    line_len++;
    if (line_len == 1) begin
      first_nul = (b == ChNul);
    end
    if (dec_phase == PhSize) begin
      scan_size_char(b);
    end
    ends    = prev_cr && b == ChLf && line_len >= 2;
    prev_cr = (b == ChCr);
    if (!ends) begin
      return;
    end
    if (dec_phase == PhSize) begin
      if (scan_bad || !digit_seen) begin
        expect_result(KindBadSize, 8'h00);
        return;
      end
      if (size_acc == 0) begin
        dec_phase = PhTrailer;
      end else begin
        chunk_left = size_acc;
        dec_phase  = PhData;
      end
      clear_line_state();
      return;
    end
    // An empty trailer line, or one that opens with NUL, closes the body.
    if (line_len == 2 || first_nul) begin
      expect_result(KindComplete, 8'h00);
      return;
    end
    clear_line_state();
  endfunction

  // Works out the result, if any, of one accepted input item.
  function automatic void decode_item(logic [1:0] act, logic [7:0] b);
    if (act == ActBegin) begin
      restart_decoder();
      live_items++;
      return;
    end
    if (act == ActEnd) begin
      if (dec_phase != PhDone) begin
        expect_result(KindTrunc, 8'h00);
        live_items++;
      end
      return;
    end
    if (act != ActByte || dec_phase == PhDone) begin
      return;
    end
    live_items++;
    case (dec_phase)
      PhSize, PhTrailer: line_char(b);
      PhData: begin
        if (chunk_left > 0) begin
          chunk_left--;
        end
        if (chunk_left == 0) begin
          dec_phase = PhCr;
        end
        expect_result(KindPayload, b);
      end
      PhCr: begin
        if (b != ChCr) begin
          expect_result(KindBadEnd, 8'h00);
        end else begin
          dec_phase = PhLf;
        end
      end
      PhLf: begin
        if (b != ChLf) begin
          expect_result(KindBadEnd, 8'h00);
        end else begin
          dec_phase = PhSize;
          clear_line_state();
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------

  function automatic void add_item(logic [1:0] act, logic [7:0] data);
    item_t it;
    it.act  = act;
    it.data = data;
    body_items.push_back(it);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      add_item(ActByte, s[i]);
    end
  endfunction

  function automatic void add_crlf();
    add_item(ActByte, ChCr);
    add_item(ActByte, ChLf);
  endfunction

  function automatic logic [7:0] hex_digit(logic [3:0] nib, bit upper);
    if (nib < 10) begin
      return 8'h30 + 8'(nib);
    end
    return (upper ? 8'h37 : 8'h57) + 8'(nib);
  endfunction

  // Size line with random case and, at random, leading zeros and an extension or a space.
  function automatic void add_size_line(logic [31:0] value);
    bit started;
    started = 1'b0;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) add_item(ActByte, 8'h30);
    end
    for (int i = 7; i >= 0; i--) begin
      if (value[4*i +: 4] != 0 || i == 0) begin
        started = 1'b1;
      end
      if (started) begin
        add_item(ActByte, hex_digit(value[4*i +: 4], 1'($urandom_range(0, 1))));
      end
    end
    case ($urandom_range(0, 7))
      0: begin
        add_item(ActByte, ChSemi);
        repeat ($urandom_range(1, 8)) add_item(ActByte, 8'($urandom_range(8'h61, 8'h7A)));
      end
      1: add_item(ActByte, ChSpace);
      default: ;
    endcase
    add_crlf();
  endfunction

  // ---------------------------------------------------------------------------
  // Input channel: bursts of transfers with random gaps between them
  // ---------------------------------------------------------------------------

  task automatic send_item(logic [1:0] act, logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    action_i    <= act;
    data_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    decode_item(act, b);
  endtask

  task automatic play_items();
    item_t it;
    while (body_items.size() != 0) begin
      it = body_items.pop_front();
      send_item(it.act, it.data);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output channel: stall pattern of its own, plus one long hold-off
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    int unsigned mode;
    int unsigned mode_left;
    bit          stall;
    mode        = 0;
    mode_left   = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        repeat (HoldOffCycles) begin
          out_stall_i <= 1'b1;
          @(posedge clk_i);
        end
        hold_off_req = 1'b0;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      case (mode)
        0: stall = 1'b0;
        1: stall = ($urandom_range(0, 3) == 0);
        2: stall = ($urandom_range(0, 9) < 7);
        default: stall = (mode_left % 3 == 0);
      endcase
      out_stall_i <= stall;
    end
  end

  // Each output transfer is compared with the oldest prediction.
  always @(posedge clk_i) begin : result_check
    result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, kind %0d out_byte %02h", $time, kind_o, out_byte_o);
        error_count++;
      end else begin
        exp_r = awaited_results.pop_front();
        if (kind_o !== exp_r.kind) begin
          $display("%0t: kind mismatch, expected %0d, actual %0d", $time, exp_r.kind, kind_o);
          error_count++;
        end
        if (out_byte_o !== exp_r.data) begin
          $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                   $time, exp_r.data, out_byte_o);
          error_count++;
        end
      end
    end
  end

  // Ends the run if neither channel completes a transfer for too long.
  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: timeout, no transfer for %0d cycles", $time, quiet_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Body with extreme payload bytes whose chunk of size A is cut off by end of input.
  task automatic test_basic_body();
    add_item(ActBegin, 8'h00);
    add_text("2;x");
    add_crlf();
    add_item(ActByte, 8'h00);
    add_item(ActByte, 8'hFF);
    add_crlf();
    add_text("A");
    add_crlf();
    add_text("z");
    add_crlf();
    add_text("0");
    add_crlf();
    add_crlf();
    add_text("Q");
    add_item(ActEnd, 8'h00);
    play_items();
  endtask

  // Bad characters, empty size, overflow, leading space, and the largest size.
  task automatic test_size_errors();
    add_item(ActBegin, 8'hFF);
    add_text("g");
    add_crlf();
    add_item(ActBegin, 8'h00);
    add_crlf();
    add_item(ActBegin, 8'h00);
    add_text("100000000");
    add_crlf();
    add_item(ActBegin, 8'h00);
    add_text(" 1");
    add_crlf();
    add_item(ActBegin, 8'h00);
    add_text("FFFFFFFF");
    add_crlf();
    add_text("pq");
    add_item(ActEnd, 8'hFF);
    play_items();
  endtask

  // The bytes after chunk data must be exactly CR then LF.
  task automatic test_chunk_end();
    add_item(ActBegin, 8'h00);
    add_text("1");
    add_crlf();
    add_text("xy");
    add_item(ActBegin, 8'h00);
    add_text("1");
    add_crlf();
    add_text("x");
    add_item(ActByte, ChCr);
    add_text("y");
    play_items();
  endtask

  // Bare CR and LF inside lines, a trailer line, and a trailer closed by a NUL line.
  task automatic test_line_ends_and_trailers();
    add_item(ActBegin, 8'h00);
    add_text("1");
    add_item(ActByte, ChCr);
    add_text("z");
    add_crlf();
    add_text("Q");
    add_crlf();
    add_text("0");
    add_item(ActByte, ChLf);
    add_crlf();
    add_text("a: b");
    add_crlf();
    add_item(ActByte, ChNul);
    add_text("q");
    add_crlf();
    play_items();
  endtask

  // End of input mid-body, repeated end, and the unused action code.
  task automatic test_end_and_unused();
    add_item(ActBegin, 8'h00);
    add_text("3");
    add_crlf();
    add_text("ab");
    add_item(ActEnd, 8'h00);
    add_item(ActEnd, 8'h00);
    add_item(ActUnused, 8'hFF);
    add_item(ActBegin, 8'h00);
    add_item(ActUnused, 8'h5A);
    add_item(ActEnd, 8'h00);
    play_items();
  endtask

  // Lines of exactly the longest allowed length, and one byte over.
  task automatic test_line_limits();
    add_item(ActBegin, 8'h00);
    add_text("1;");
    repeat (LineCap - 5) add_item(ActByte, 8'h78);
    add_crlf();
    add_item(ActByte, 8'h5A);
    add_crlf();
    add_text("0");
    add_crlf();
    add_text("t:");
    repeat (LineCap - 5) add_item(ActByte, 8'h79);
    add_crlf();
    repeat (LineCap) add_item(ActByte, 8'h7A);
    add_item(ActEnd, 8'h00);
    add_item(ActBegin, 8'h00);
    add_text("2;");
    repeat (LineCap - 4) add_item(ActByte, 8'h78);
    add_crlf();
    play_items();
  endtask

  // The receiver holds off while a long chunk streams in.
  task automatic test_output_hold_off();
    hold_off_req = 1'b1;
    burst_left   = 200;
    add_item(ActBegin, 8'h00);
    add_size_line(32'h40);
    repeat (32'h40) add_item(ActByte, 8'($urandom_range(0, 255)));
    add_crlf();
    add_size_line(32'h0);
    add_crlf();
    add_item(ActEnd, 8'h00);
    play_items();
  endtask

  // Random well-formed bodies, some of them damaged.
  task automatic test_random_bodies();
    int unsigned len;
    int unsigned pick;
    int unsigned pos;
    item_t       extra;
    while (live_items < ItemTarget) begin
      add_item(ActBegin, 8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 4)) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
        add_size_line(len);
        repeat (len) add_item(ActByte, 8'($urandom_range(0, 255)));
        add_crlf();
      end
      add_size_line(32'h0);
      repeat ($urandom_range(0, 2)) begin
        repeat ($urandom_range(1, 12)) add_item(ActByte, 8'($urandom_range(33, 126)));
        add_crlf();
      end
      if ($urandom_range(0, 6) == 0) begin
        add_item(ActByte, ChNul);
        repeat ($urandom_range(0, 5)) add_item(ActByte, 8'($urandom_range(33, 126)));
      end
      add_crlf();
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) add_item(ActByte, 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 1) == 1) begin
        add_item(ActEnd, 8'($urandom_range(0, 255)));
      end

      // Damage about a third of the bodies.
      pick = $urandom_range(0, 99);
      pos  = $urandom_range(1, body_items.size() - 1);
      extra.act  = ActByte;
      extra.data = 8'($urandom_range(0, 255));
      if (pick < 8) begin
        body_items[pos] = extra;
      end else if (pick < 14) begin
        while (body_items.size() > pos) void'(body_items.pop_back());
        add_item(ActEnd, 8'($urandom_range(0, 255)));
      end else if (pick < 18) begin
        extra.act = ActBegin;
        body_items.insert(pos, extra);
      end else if (pick < 22) begin
        extra.act = ActUnused;
        body_items.insert(pos, extra);
      end else if (pick < 26) begin
        repeat ($urandom_range(40, 70)) begin
          extra.data = 8'($urandom_range(33, 126));
          body_items.insert(pos, extra);
        end
      end else if (pick < 30) begin
        body_items.delete(pos);
      end
      play_items();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin : main
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    action_i    <= ActByte;
    data_byte_i <= 8'h00;
    restart_decoder();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_body();
    test_size_errors();
    test_chunk_end();
    test_line_ends_and_trailers();
    test_end_and_unused();
    test_line_limits();
    test_output_hold_off();
    test_random_bodies();

    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (awaited_results.size() != 0) begin
      $display("%0t: %0d predicted results never arrived", $time, awaited_results.size());
      error_count++;
    end

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/hcbd_pkg.sv
rtl/core/hcbd_scan.sv
rtl/core/hcbd_core.sv
rtl/core/http_chunked_body_decoder.sv
tb/sv/testbench.sv
